### rtl/core/message_fragmenter_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the message fragmenter
// Shared concurrent-check shorthands, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef MESSAGE_FRAGMENTER_CORE_ASSERT_SVH
`define MESSAGE_FRAGMENTER_CORE_ASSERT_SVH

// Condition holds at every edge outside reset.
`define FMF_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("fmf check failed: invariant");

// Antecedent implies consequent in the same cycle.
`define FMF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fmf check failed: implication");

// Antecedent implies consequent in the following cycle.
`define FMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fmf check failed: next-cycle implication");

`endif

### rtl/core/fmf_pkg.sv
// ---------------------------------------------------------------------------
// Message fragmenter package
// Shared types, codes and constants for the fragmenter core.
// ---------------------------------------------------------------------------
package fmf_pkg;

   localparam int FRAME_BYTES  = 255;
   localparam int HDR_BYTES    = 22;
   localparam int PREFIX_BYTES = 8;
   localparam int QUEUE_DEPTH  = 4;

   // Byte index within one command's output run
   localparam int IDX_W = 5;
   localparam logic [IDX_W-1:0] IDX_FIRST    = IDX_W'(0);
   localparam logic [IDX_W-1:0] IDX_PAYLOAD  = IDX_W'(HDR_BYTES);
   localparam logic [IDX_W-1:0] IDX_LEN_HI   = IDX_W'(HDR_BYTES + PREFIX_BYTES - 2);
   localparam logic [IDX_W-1:0] IDX_LEN_LO   = IDX_W'(HDR_BYTES + PREFIX_BYTES - 1);

   localparam logic [47:0] BCAST_MAC        = 48'hFFFF_FFFF_FFFF;
   localparam logic [15:0] ETHER_TYPE_RESET = 16'h1234;

   // Request opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   // Register indexes
   localparam logic [1:0] CSR_DEST_MAC   = 2'd0;
   localparam logic [1:0] CSR_SRC_MAC    = 2'd1;
   localparam logic [1:0] CSR_BROADCAST  = 2'd2;
   localparam logic [1:0] CSR_ETHER_TYPE = 2'd3;

   // Command kinds passed from front to back
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_DATA  = 2'd1;
   localparam logic [1:0] CMD_ERROR = 2'd2;

   typedef struct packed {
      logic        op;
      logic [15:0] message_length;
      logic [31:0] message_id;
      logic [7:0]  data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_last;
      logic       message_last;
      logic       error;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [47:0] data;
   } csr_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        hdr;
      logic [31:0] id;
      logic [31:0] seq;
      logic [15:0] len;
      logic [7:0]  data;
      logic        fl;
      logic        ml;
   } cmd_type;

   typedef struct packed {
      logic [47:0] dst;
      logic [47:0] src;
      logic [15:0] ether_type;
   } cfg_type;

endpackage

### rtl/core/fmf_if.sv
// ---------------------------------------------------------------------------
// Message fragmenter channel interfaces
// Valid/ready channels for request, response and register write traffic.
// ---------------------------------------------------------------------------
interface fmf_req_if;
   logic                     valid;
   logic                     ready;
   fmf_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fmf_rsp_if;
   logic                     valid;
   logic                     ready;
   fmf_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fmf_csr_if;
   logic                     valid;
   logic                     ready;
   fmf_pkg::csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/fmf_front.sv
// ---------------------------------------------------------------------------
// Fragmenter front end
// Accepts request transfers, tracks message framing and issues commands.
// ---------------------------------------------------------------------------
module fmf_front #(
   parameter int FRAME_BYTES = fmf_pkg::FRAME_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   fmf_req_if.sink          req,
   input  logic             q_ready,
   output logic             q_push,
   output fmf_pkg::cmd_type q_cmd
);

   localparam int FILL_W = $clog2(FRAME_BYTES + 1);
   localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(FRAME_BYTES);
   localparam logic [FILL_W-1:0] FILL_HDR   = FILL_W'(fmf_pkg::HDR_BYTES);
   localparam logic [FILL_W-1:0] FILL_START =
      FILL_W'(fmf_pkg::HDR_BYTES + fmf_pkg::PREFIX_BYTES);

   logic [15:0]       left_ff, left_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [31:0]       seq_ff, seq_in;
   logic [31:0]       id_ff, id_in;
   logic              accept;
   logic              need_hdr;
   logic [FILL_W-1:0] fill_new;
   logic [15:0]       left_new;

   assign req.ready = q_ready;
   assign accept    = req.valid && q_ready;
   assign q_push    = accept;

   // Data-item framing: open a new frame once the current one is full
   assign need_hdr = (fill_ff >= FILL_FULL);
   assign fill_new = (need_hdr ? FILL_HDR : fill_ff) + FILL_W'(1);
   assign left_new = left_ff - 16'd1;

   always_comb begin
      left_in = left_ff;
      fill_in = fill_ff;
      seq_in  = seq_ff;
      id_in   = id_ff;
      q_cmd.kind = fmf_pkg::CMD_ERROR;
      q_cmd.hdr  = 1'b0;
      q_cmd.id   = id_ff;
      q_cmd.seq  = seq_ff;
      q_cmd.len  = req.payload.message_length;
      q_cmd.data = 8'd0;
      q_cmd.fl   = 1'b0;
      q_cmd.ml   = 1'b0;
      priority if (req.payload.op == fmf_pkg::OP_START) begin
         q_cmd.kind = fmf_pkg::CMD_START;
         q_cmd.id   = req.payload.message_id;
         q_cmd.seq  = 32'd0;
         q_cmd.fl   = (req.payload.message_length == 16'd0);
         q_cmd.ml   = (req.payload.message_length == 16'd0);
         if (accept) begin
            id_in   = req.payload.message_id;
            seq_in  = 32'd0;
            fill_in = FILL_START;
            left_in = req.payload.message_length;
         end
      end else if (left_ff == 16'd0) begin
         // no open message: error transfer, byte dropped
      end else begin
         q_cmd.kind = fmf_pkg::CMD_DATA;
         q_cmd.hdr  = need_hdr;
         q_cmd.seq  = need_hdr ? seq_ff + 32'd1 : seq_ff;
         q_cmd.data = req.payload.data_byte;
         q_cmd.ml   = (left_new == 16'd0);
         q_cmd.fl   = (left_new == 16'd0) || (fill_new >= FILL_FULL);
         if (accept) begin
            seq_in  = q_cmd.seq;
            fill_in = fill_new;
            left_in = left_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         fill_ff <= '0;
         seq_ff  <= '0;
         id_ff   <= '0;
      end else begin
         left_ff <= left_in;
         fill_ff <= fill_in;
         seq_ff  <= seq_in;
         id_ff   <= id_in;
      end
   end

endmodule

### rtl/core/fmf_queue.sv
// ---------------------------------------------------------------------------
// Fragmenter command queue
// Small FIFO that decouples the front end from the byte sequencer.
// ---------------------------------------------------------------------------
module fmf_queue #(
   parameter int DEPTH = fmf_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fmf_pkg::cmd_type push_cmd,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output fmf_pkg::cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fmf_pkg::cmd_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_cmd    = slot_ff[rd_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/core/fmf_back.sv
// ---------------------------------------------------------------------------
// Fragmenter byte sequencer
// Expands queued commands into header, prefix and payload byte transfers.
// ---------------------------------------------------------------------------
`include "message_fragmenter_core_assert.svh"

module fmf_back (
   input  logic             clock,
   input  logic             reset,
   input  fmf_pkg::cfg_type cfg,
   input  logic             q_valid,
   input  fmf_pkg::cmd_type q_cmd,
   output logic             q_pop,
   fmf_rsp_if.source        rsp
);

   localparam int HDR_W = 8 * fmf_pkg::HDR_BYTES;

   fmf_pkg::cmd_type          cur_ff, cur_in;
   logic                      busy_ff, busy_in;
   logic [fmf_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   fmf_pkg::rsp_payload_type  rsp_ff, rsp_in;
   logic [HDR_W-1:0]          hdr_vec;
   logic [7:0]                hdr_byte;
   logic                      emit, at_last, load;
   logic [fmf_pkg::IDX_W-1:0] last_idx;

   assign hdr_vec  = {cfg.dst, cfg.src, cfg.ether_type, cur_ff.id, cur_ff.seq};
   assign hdr_byte = hdr_vec[HDR_W - 1 - 8 * int'(idx_ff) -: 8];

   assign last_idx = (cur_ff.kind == fmf_pkg::CMD_START) ? fmf_pkg::IDX_LEN_LO
                                                         : fmf_pkg::IDX_PAYLOAD;
   assign at_last  = (idx_ff == last_idx);
   assign emit     = busy_ff && (!rsp_valid_ff || rsp.ready);
   assign load     = q_valid && (!busy_ff || (emit && at_last));
   assign q_pop    = load;

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (emit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.frame_last   = at_last && cur_ff.fl;
         rsp_in.message_last = at_last && cur_ff.ml;
         rsp_in.error        = (cur_ff.kind == fmf_pkg::CMD_ERROR);
         priority if (idx_ff < fmf_pkg::IDX_PAYLOAD) begin
            rsp_in.out_byte = hdr_byte;
         end else if (cur_ff.kind != fmf_pkg::CMD_START) begin
            rsp_in.out_byte = cur_ff.data;
         end else if (idx_ff == fmf_pkg::IDX_LEN_HI) begin
            rsp_in.out_byte = cur_ff.len[15:8];
         end else if (idx_ff == fmf_pkg::IDX_LEN_LO) begin
            rsp_in.out_byte = cur_ff.len[7:0];
         end else begin
            rsp_in.out_byte = 8'd0;
         end
      end
   end

   // Command sequencing: start and header-bearing data begin at the header,
   // plain data and error transfers jump straight to the payload slot
   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (emit) begin
         idx_in = idx_ff + fmf_pkg::IDX_W'(1);
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         cur_in  = q_cmd;
         busy_in = 1'b1;
         idx_in  = (q_cmd.kind == fmf_pkg::CMD_START || q_cmd.hdr)
                   ? fmf_pkg::IDX_FIRST : fmf_pkg::IDX_PAYLOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   `FMF_ASSERT_IMPL(a_idx_range, clock, reset, busy_ff, idx_ff <= fmf_pkg::IDX_LEN_LO)
   `FMF_ASSERT_IMPL(a_pop_on_free, clock, reset, q_pop, !busy_ff || (emit && at_last))
   `FMF_ASSERT_IMPL(a_msg_ends_frame, clock, reset, rsp_valid_ff && rsp_ff.message_last, rsp_ff.frame_last)
   `FMF_ASSERT_IMPL(a_error_clean, clock, reset, rsp_valid_ff && rsp_ff.error, !rsp_ff.frame_last && !rsp_ff.message_last && rsp_ff.out_byte == 8'd0)
   `FMF_ASSERT_NEXT(a_emit_shows, clock, reset, emit, rsp_valid_ff)

endmodule

### rtl/core/message_fragmenter_core.sv
// ---------------------------------------------------------------------------
// Message fragmenter core
// Splits a byte stream into framed messages with a 22-byte header each.
// ---------------------------------------------------------------------------
// A start transfer opens a message and yields 30 response bytes (22-byte
// header, then an 8-byte big-endian length prefix); each data transfer yields
// its payload byte, preceded by a fresh 22-byte header when the current frame
// already holds FRAME_BYTES bytes, or one error byte when no message is open.
// The byte sequencer sends one response transfer per clock while rsp takes them; the
// front end accepts one request transfer per clock as long as the four-entry command
// queue has room, and the queue keeps taking commands while a byte waits on rsp (the
// sequencer holds until that byte is taken).
// Register writes are taken at any time (csr.ready is tied high) but must only
// be issued while the block is idle; the header reads them live.
// ---------------------------------------------------------------------------
module message_fragmenter_core #(
   parameter int FRAME_BYTES = fmf_pkg::FRAME_BYTES,
   parameter int QUEUE_DEPTH = fmf_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   fmf_req_if.sink    req,
   fmf_rsp_if.source  rsp,
   fmf_csr_if.sink    csr
);

   logic [47:0]      dest_mac_ff;
   logic [47:0]      src_mac_ff;
   logic             broadcast_ff;
   logic [15:0]      ether_type_ff;
   fmf_pkg::cfg_type cfg;

   logic             push, push_ready, pop, pop_valid;
   fmf_pkg::cmd_type push_cmd, pop_cmd;

   // Register file: take every write transfer immediately
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_mac_ff   <= '0;
         src_mac_ff    <= '0;
         broadcast_ff  <= 1'b0;
         ether_type_ff <= fmf_pkg::ETHER_TYPE_RESET;
      end else if (csr.valid) begin
         unique case (csr.payload.index)
            fmf_pkg::CSR_DEST_MAC:   dest_mac_ff   <= csr.payload.data;
            fmf_pkg::CSR_SRC_MAC:    src_mac_ff    <= csr.payload.data;
            fmf_pkg::CSR_BROADCAST:  broadcast_ff  <= csr.payload.data[0];
            fmf_pkg::CSR_ETHER_TYPE: ether_type_ff <= csr.payload.data[15:0];
            default: ;
         endcase
      end
   end

   // Broadcast mode replaces the destination with all ones
   assign cfg.dst        = broadcast_ff ? fmf_pkg::BCAST_MAC : dest_mac_ff;
   assign cfg.src        = src_mac_ff;
   assign cfg.ether_type = ether_type_ff;

   // Front: classify each request and advance frame bookkeeping
   fmf_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_ready (push_ready),
      .q_push  (push),
      .q_cmd   (push_cmd)
   );

   // Queue: hold commands while the sequencer is still emitting bytes
   fmf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd)
   );

   // Back: expand commands into response byte transfers
   fmf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (pop_valid),
      .q_cmd   (pop_cmd),
      .q_pop   (pop),
      .rsp     (rsp)
   );

endmodule

### bench/tb.sv
// ---------------------------------------------------------------------------
// Message fragmenter core testbench
// Feeds start and payload transfers through the request channel, predicts
// every framed response byte from a local model of the segmentation logic,
// and checks the response stream byte for byte under random idling and stalls.
// ---------------------------------------------------------------------------
module tb;

   localparam int HOLD_CYCLES  = 400;  // long receiver stall for the backpressure test
   localparam int DRAIN_CYCLES = 40;   // quiet time after the last expected byte

   logic clock = 1'b0;
   logic reset;

   fmf_req_if req_bus ();
   fmf_rsp_if rsp_bus ();
   fmf_csr_if csr_bus ();

   message_fragmenter_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // Free-running clock, period 4.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle percentages for both sides, changed per phase by the tests.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // Receiver hold-off: a test bumps hold_seq, the receiver process counts it down.
   int unsigned hold_seq  = 0;
   int unsigned hold_seen = 0;
   int          hold_left = 0;

   int errors = 0;

   // ------------------------------------------------------------------------
   // Local model of the fragmenter: register copies and framing state
   // ------------------------------------------------------------------------
   logic [47:0] link_dest  = '0;
   logic [47:0] link_src   = '0;
   logic        link_bcast = 1'b0;
   logic [15:0] link_etype = fmf_pkg::ETHER_TYPE_RESET;

   logic        msg_open   = 1'b0;
   logic [31:0] msg_id     = '0;
   logic [31:0] frame_no   = '0;
   logic [10:0] frame_used = '0;
   logic [16:0] payload_left = '0;

   // Framed bytes still owed by the block, oldest first.
   fmf_pkg::rsp_payload_type frame_bytes_due[$];
   fmf_pkg::rsp_payload_type want_byte;

   function automatic void owe_byte(input logic [7:0] b, input logic fl, input logic ml,
                                    input logic err);
      fmf_pkg::rsp_payload_type r;
      r.out_byte     = b;
      r.frame_last   = fl;
      r.message_last = ml;
      r.error        = err;
      frame_bytes_due.push_back(r);
   endfunction

   function automatic void owe_big_endian(input logic [63:0] v, input int count);
      for (int i = count - 1; i >= 0; i--) owe_byte(v[8*i +: 8], 1'b0, 1'b0, 1'b0);
   endfunction

   function automatic void owe_header();
      owe_big_endian(64'(link_bcast ? fmf_pkg::BCAST_MAC : link_dest), 6);
      owe_big_endian(64'(link_src), 6);
      owe_big_endian(64'(link_etype), 2);
      owe_big_endian(64'(msg_id), 4);
      owe_big_endian(64'(frame_no), 4);
      frame_used = 11'(fmf_pkg::HDR_BYTES);
   endfunction

   // Advance the model by one accepted request and queue the bytes it yields.
   function automatic void fragment_item(input fmf_pkg::req_payload_type it);
      logic [7:0] b;
      logic       last;
      logic       fl;
      logic       ml;
      if (it.op == fmf_pkg::OP_START) begin
         msg_id   = it.message_id;
         frame_no = '0;
         owe_header();
         // Length prefix: eight bytes, only the low two can be nonzero.
         for (int i = 0; i < fmf_pkg::PREFIX_BYTES; i++) begin
            b    = 8'h00;
            last = (i == fmf_pkg::PREFIX_BYTES - 1) && (it.message_length == 16'd0);
            if (i == fmf_pkg::PREFIX_BYTES - 2) b = it.message_length[15:8];
            if (i == fmf_pkg::PREFIX_BYTES - 1) b = it.message_length[7:0];
            owe_byte(b, last, last, 1'b0);
            frame_used++;
         end
         payload_left = {1'b0, it.message_length};
         msg_open     = (it.message_length != 16'd0);
      end else if (!msg_open || payload_left == '0) begin
         // Stray byte or one past the declared length: one error byte, data dropped.
         msg_open = 1'b0;
         owe_byte(8'h00, 1'b0, 1'b0, 1'b1);
      end else begin
         if (frame_used >= fmf_pkg::FRAME_BYTES) begin
            frame_no++;
            owe_header();
         end
         frame_used++;
         payload_left--;
         ml = (payload_left == '0);
         fl = ml || (frame_used >= fmf_pkg::FRAME_BYTES);
         owe_byte(it.data_byte, fl, ml, 1'b0);
         if (ml) msg_open = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request builders; fields the block ignores get random values
   // ------------------------------------------------------------------------
   function automatic fmf_pkg::req_payload_type start_req(input logic [15:0] len,
                                                          input logic [31:0] id);
      fmf_pkg::req_payload_type it;
      it.op             = fmf_pkg::OP_START;
      it.message_length = len;
      it.message_id     = id;
      it.data_byte      = 8'($urandom);
      return it;
   endfunction

   function automatic fmf_pkg::req_payload_type data_req(input logic [7:0] b);
      fmf_pkg::req_payload_type it;
      it.op             = fmf_pkg::OP_DATA;
      it.message_length = 16'($urandom);
      it.message_id     = $urandom;
      it.data_byte      = b;
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // Driving side
   // ------------------------------------------------------------------------

   // Offer one request; idle first at random, then hold it until the transfer.
   // Valid stays high after the transfer so back-to-back items need no gap.
   task automatic send_item(input fmf_pkg::req_payload_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.payload <= it;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      fragment_item(it);
   endtask

   // Drop valid and wait until every owed byte has come out, then let the
   // block go quiet.
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
      fmf_pkg::csr_payload_type w;
      w.index = idx;
      w.data  = value;
      @(negedge clock);
      csr_bus.valid   <= 1'b1;
      csr_bus.payload <= w;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      case (idx)
         fmf_pkg::CSR_DEST_MAC:   link_dest  = value;
         fmf_pkg::CSR_SRC_MAC:    link_src   = value;
         fmf_pkg::CSR_BROADCAST:  link_bcast = value[0];
         fmf_pkg::CSR_ETHER_TYPE: link_etype = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Reprogram the whole link setup; only ever done with the block drained.
   task automatic program_link(input logic [47:0] dest, input logic [47:0] src,
                               input logic bcast, input logic [15:0] etype);
      settle();
      write_reg(fmf_pkg::CSR_DEST_MAC, dest);
      write_reg(fmf_pkg::CSR_SRC_MAC, src);
      write_reg(fmf_pkg::CSR_BROADCAST, {47'd0, bcast});
      write_reg(fmf_pkg::CSR_ETHER_TYPE, {32'd0, etype});
   endtask

   // Receiver: a pending hold-off wins, otherwise accept at random.
   always @(negedge clock) begin
      if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Response checker: compare every transfer against the oldest owed byte
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (frame_bytes_due.size() == 0) begin
            $display("%0t: unexpected response, expected none, got byte %h fl %b ml %b err %b",
                     $time, rsp_bus.payload.out_byte, rsp_bus.payload.frame_last,
                     rsp_bus.payload.message_last, rsp_bus.payload.error);
            errors++;
         end else begin
            want_byte = frame_bytes_due.pop_front();
            if (rsp_bus.payload.out_byte !== want_byte.out_byte) begin
               $display("%0t: out_byte expected %h got %h", $time,
                        want_byte.out_byte, rsp_bus.payload.out_byte);
               errors++;
            end
            if (rsp_bus.payload.frame_last !== want_byte.frame_last) begin
               $display("%0t: frame_last expected %b got %b", $time,
                        want_byte.frame_last, rsp_bus.payload.frame_last);
               errors++;
            end
            if (rsp_bus.payload.message_last !== want_byte.message_last) begin
               $display("%0t: message_last expected %b got %b", $time,
                        want_byte.message_last, rsp_bus.payload.message_last);
               errors++;
            end
            if (rsp_bus.payload.error !== want_byte.error) begin
               $display("%0t: error expected %b got %b", $time,
                        want_byte.error, rsp_bus.payload.error);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Payload bytes with no message open must each come back as one error byte.
   task automatic test_stray_data();
      send_item(data_req(8'h00));
      send_item(data_req(8'hFF));
   endtask

   // Empty message under reset register values: header plus prefix, with both
   // last flags on the final prefix byte.
   task automatic test_reset_config();
      send_item(start_req(16'd0, 32'd0));
   endtask

   // Drive every register to its extremes; broadcast must override the
   // destination even when that is all zeros.
   task automatic test_register_extremes();
      program_link(48'hFFFF_FFFF_FFFF, 48'd0, 1'b0, 16'hFFFF);
      send_item(start_req(16'd1, 32'hFFFF_FFFF));
      send_item(data_req(8'hFF));
      program_link(48'd0, 48'hFFFF_FFFF_FFFF, 1'b1, 16'h0000);
      send_item(start_req(16'd0, 32'h5A5A_A5A5));
   endtask

   // Short message with byte extremes, one byte past its length, a maximum
   // length message abandoned by a new start, and that one completed.
   task automatic test_message_edges();
      program_link(48'h0200_DEAD_BEEF, 48'h0211_2233_4455, 1'b0, 16'h88B5);
      send_item(start_req(16'd3, 32'h0123_4567));
      send_item(data_req(8'h00));
      send_item(data_req(8'hFF));
      send_item(data_req(8'hA5));
      send_item(data_req(8'h3C));
      send_item(start_req(16'hFFFF, 32'hFFFF_FFFF));
      send_item(data_req(8'h5A));
      send_item(data_req(8'h81));
      send_item(start_req(16'd2, 32'd0));
      send_item(data_req(8'h7E));
      send_item(data_req(8'h01));
   endtask

   // Message that fills the first frame to the brim and spills its last
   // byte into a second frame with a fresh header.
   task automatic test_frame_split();
      int len;
      len = fmf_pkg::FRAME_BYTES - fmf_pkg::HDR_BYTES - fmf_pkg::PREFIX_BYTES + 1;
      send_item(start_req(16'(len), $urandom));
      repeat (len) send_item(data_req(8'($urandom)));
      settle();
   endtask

   // Stall the receiver for a long stretch while starts keep coming, so the
   // command queue fills and the block has to hold off the sender.
   task automatic test_backpressure();
      settle();
      hold_seq++;
      repeat (6) begin
         send_item(start_req(16'd2, $urandom));
         send_item(data_req(8'($urandom)));
         send_item(data_req(8'($urandom)));
      end
      settle();
   endtask

   // Mostly well-formed messages with random content; the rest are messages
   // cut short by a new start, bytes past the end, and stray bytes.
   task automatic test_random_traffic(input int unsigned send_pct,
                                      input int unsigned recv_pct, input int n_items);
      int          sent;
      int unsigned kind;
      int unsigned len;
      int unsigned cut;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent          = 0;
      program_link(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), 1'($urandom),
                   16'($urandom));
      while (sent < n_items) begin
         kind = $urandom_range(99);
         if (kind < 75) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(2) : $urandom_range(40);
            send_item(start_req(16'(len), $urandom));
            sent++;
            repeat (len) begin
               send_item(data_req(8'($urandom)));
               sent++;
            end
            if ($urandom_range(9) == 0) begin
               send_item(data_req(8'($urandom)));
               sent++;
            end
         end else if (kind < 90) begin
            len = $urandom_range(65535);
            cut = $urandom_range(6);
            send_item(start_req(16'(len), $urandom));
            sent++;
            repeat (cut) begin
               send_item(data_req(8'($urandom)));
               sent++;
            end
         end else begin
            send_item(data_req(8'($urandom)));
            sent++;
         end
      end
      settle();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      // Hold every input at a known value from time zero.
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.payload = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender rarely idles, receiver mostly stalls.
      send_idle_pct = 6;
      recv_idle_pct = 80;
      test_stray_data();
      test_reset_config();
      test_register_extremes();
      test_message_edges();
      test_frame_split();
      test_random_traffic(6, 80, 30);

      // Sender mostly idles, receiver rarely stalls.
      test_random_traffic(80, 6, 30);
      test_backpressure();

      // Full rate on both sides.
      test_random_traffic(0, 0, 30);

      settle();
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: end the run if traffic stops moving.
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
